/* rtl/sltab_pkg.sv */
// Package for the sorted leaf key table: field widths, action and status
// codes, word types and the controller state type. No dependencies.
package sltab_pkg;

  localparam int KEY_W           = 32;
  localparam int VALUE_W         = 64;
  localparam int FIELD_W         = 3;
  localparam int INDEX_W         = 5;
  localparam int DEF_CELLS       = 16;
  localparam int DEF_VALUE_WIDTH = 64;

  localparam logic [FIELD_W-1:0] ACT_START   = 3'd0;
  localparam logic [FIELD_W-1:0] ACT_FIND    = 3'd1;
  localparam logic [FIELD_W-1:0] ACT_READ    = 3'd2;
  localparam logic [FIELD_W-1:0] ACT_ADVANCE = 3'd3;
  localparam logic [FIELD_W-1:0] ACT_INSERT  = 3'd4;

  localparam logic [FIELD_W-1:0] STAT_OK        = 3'd0;
  localparam logic [FIELD_W-1:0] STAT_NOT_FOUND = 3'd1;
  localparam logic [FIELD_W-1:0] STAT_DUPLICATE = 3'd2;
  localparam logic [FIELD_W-1:0] STAT_FULL      = 3'd3;
  localparam logic [FIELD_W-1:0] STAT_AT_END    = 3'd4;

  typedef struct packed {
    logic [FIELD_W-1:0] action;
    logic [KEY_W-1:0]   search_key;
    logic [VALUE_W-1:0] new_value;
  } sltab_cmd_t;

  typedef struct packed {
    logic [FIELD_W-1:0] status;
    logic [INDEX_W-1:0] position;
    logic [KEY_W-1:0]   found_key;
    logic [VALUE_W-1:0] found_value;
    logic               at_end;
    logic [INDEX_W-1:0] cell_count;
  } sltab_result_t;

  typedef struct packed {
    logic init;
    logic step;
  } sltab_srch_ctl_t;

  typedef struct packed {
    logic done;
    logic hit;
  } sltab_srch_sts_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_COMPARE,
    ST_SHIFT,
    ST_WRITE,
    ST_READ
  } sltab_state_t;

endpackage

/* rtl/sltab_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module sltab_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/sltab_search.sv */
// Binary search bounds for the sorted leaf key table: holds the low and high
// bounds, proposes the probe cell and narrows on each compared key.
// Depends on sltab_pkg.
module sltab_search #(
  parameter int CELLS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  sltab_pkg::sltab_srch_ctl_t       ctl,
  input  logic [$clog2(CELLS+1)-1:0]       upper,
  input  logic [sltab_pkg::KEY_W-1:0]      key,
  input  logic [sltab_pkg::KEY_W-1:0]      probe_key,
  output logic [$clog2(CELLS)-1:0]         mid,
  output logic [$clog2(CELLS+1)-1:0]       pos,
  output sltab_pkg::sltab_srch_sts_t       sts
);
  import sltab_pkg::*;

  localparam int CNT_W = $clog2(CELLS + 1);
  localparam int IDX_W = $clog2(CELLS);

  logic [CNT_W-1:0] lo;
  logic [CNT_W-1:0] hi;
  logic             hit;
  logic [CNT_W:0]   sum;
  logic [CNT_W-1:0] mid_full;

  assign sum      = {1'b0, lo} + {1'b0, hi};
  assign mid_full = sum[CNT_W:1];
  assign mid      = mid_full[IDX_W-1:0];
  assign pos      = lo;
  assign sts.done = (lo >= hi);
  assign sts.hit  = hit;

  // A match collapses both bounds onto the probe cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      lo  <= '0;
      hi  <= '0;
      hit <= 1'b0;
    end else if (ctl.init) begin
      lo  <= '0;
      hi  <= upper;
      hit <= 1'b0;
    end else if (ctl.step) begin
      if (probe_key == key) begin
        lo  <= mid_full;
        hi  <= mid_full;
        hit <= 1'b1;
      end else if (key > probe_key) begin
        lo <= mid_full + 1'b1;
      end else begin
        hi <= mid_full;
      end
    end
  end

endmodule

/* rtl/sorted_leaf_key_table.sv */
// Top level of the sorted leaf key table: command controller, cursor state
// and cell memory. Depends on sltab_pkg, sltab_ram and sltab_search.
//
// A command word is taken when start is high and busy is low; its result word
// appears on result with done high for exactly one cycle and cannot be held
// off. Start, advance, a read past the end and unknown actions finish without
// leaving the idle state. A read issues its memory read from idle and answers
// from the READ state. Find steps through SEARCH and COMPARE, since every
// probe of the binary search is a memory read followed by a compare. Insert
// searches the same way; on success it moves each cell from the position up
// in the SHIFT state, one at a time because cells share one write port, and
// writes the new cell in the WRITE state.
module sorted_leaf_key_table #(
  parameter int CELLS       = sltab_pkg::DEF_CELLS,
  parameter int VALUE_WIDTH = sltab_pkg::DEF_VALUE_WIDTH
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  sltab_pkg::sltab_cmd_t     cmd,
  output logic                      busy,
  output logic                      done,
  output sltab_pkg::sltab_result_t  result
);
  import sltab_pkg::*;

  localparam int CNT_W = $clog2(CELLS + 1);
  localparam int IDX_W = $clog2(CELLS);
  localparam int MEM_W = KEY_W + VALUE_WIDTH;

  sltab_state_t state, state_next;

  logic [CNT_W-1:0]       used, used_next;
  logic [CNT_W-1:0]       cursor, cursor_next;
  logic                   end_flag, end_flag_next;
  logic [CNT_W-1:0]       idx, idx_next;
  logic [FIELD_W-1:0]     act;
  logic [KEY_W-1:0]       key;
  logic [VALUE_WIDTH-1:0] val;
  logic                   done_next;
  sltab_result_t          result_next;

  logic                   emit;
  logic [FIELD_W-1:0]     emit_status;
  logic                   emit_data;

  logic                   ram_we;
  logic [IDX_W-1:0]       ram_waddr;
  logic [MEM_W-1:0]       ram_wdata;
  logic                   ram_re;
  logic [IDX_W-1:0]       ram_raddr;
  logic [MEM_W-1:0]       ram_rdata;

  sltab_srch_ctl_t        srch_ctl;
  sltab_srch_sts_t        srch_sts;
  logic [IDX_W-1:0]       srch_mid;
  logic [CNT_W-1:0]       srch_pos;

  logic                   accept;
  logic [CNT_W-1:0]       idx_dec;
  logic [CNT_W-1:0]       adv_pos;

  function automatic logic [IDX_W-1:0] idx_dec_of(input logic [CNT_W-1:0] n);
    logic [CNT_W-1:0] d;
    begin
      d = n - 1'b1;
      return d[IDX_W-1:0];
    end
  endfunction

  assign busy    = (state != ST_IDLE);
  assign accept  = start && !busy;
  assign idx_dec = idx - 1'b1;
  assign adv_pos = (cursor < used) ? cursor + 1'b1 : used;

  sltab_ram #(
    .WIDTH(MEM_W),
    .DEPTH(CELLS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  sltab_search #(
    .CELLS(CELLS)
  ) u_search (
    .clk      (clk),
    .rst      (rst),
    .ctl      (srch_ctl),
    .upper    (used),
    .key      (key),
    .probe_key(ram_rdata[VALUE_WIDTH +: KEY_W]),
    .mid      (srch_mid),
    .pos      (srch_pos),
    .sts      (srch_sts)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (cmd.action == ACT_FIND || cmd.action == ACT_INSERT) begin
            state_next = ST_SEARCH;
          end else if (cmd.action == ACT_READ && cursor < used) begin
            state_next = ST_READ;
          end
        end
      end
      ST_SEARCH: begin
        if (srch_sts.done) begin
          if (act == ACT_INSERT && !srch_sts.hit && used < CNT_W'(CELLS)) begin
            state_next = (srch_pos == used) ? ST_WRITE : ST_SHIFT;
          end else begin
            state_next = ST_IDLE;
          end
        end else begin
          state_next = ST_COMPARE;
        end
      end
      ST_COMPARE: state_next = ST_SEARCH;
      ST_SHIFT: begin
        if (idx_dec <= cursor) begin
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: state_next = ST_IDLE;
      ST_READ:  state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    used_next     = used;
    cursor_next   = cursor;
    end_flag_next = end_flag;
    idx_next      = idx;
    emit          = 1'b0;
    emit_status   = STAT_OK;
    emit_data     = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = idx[IDX_W-1:0];
    ram_wdata     = ram_rdata;
    ram_re        = 1'b0;
    ram_raddr     = srch_mid;
    srch_ctl      = '0;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (cmd.action)
            ACT_START: begin
              cursor_next   = '0;
              end_flag_next = (used == '0);
              emit          = 1'b1;
              emit_status   = (used == '0) ? STAT_AT_END : STAT_OK;
            end
            ACT_FIND, ACT_INSERT: begin
              srch_ctl.init = 1'b1;
            end
            ACT_READ: begin
              if (cursor < used) begin
                ram_re    = 1'b1;
                ram_raddr = cursor[IDX_W-1:0];
              end else begin
                emit        = 1'b1;
                emit_status = STAT_AT_END;
              end
            end
            ACT_ADVANCE: begin
              cursor_next   = adv_pos;
              end_flag_next = (adv_pos >= used);
              emit          = 1'b1;
              emit_status   = (adv_pos >= used) ? STAT_AT_END : STAT_OK;
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      ST_SEARCH: begin
        if (srch_sts.done) begin
          cursor_next = srch_pos;
          if (act == ACT_FIND) begin
            end_flag_next = (srch_pos >= used);
            emit          = 1'b1;
            emit_status   = srch_sts.hit ? STAT_OK : STAT_NOT_FOUND;
          end else if (srch_sts.hit) begin
            end_flag_next = 1'b0;
            emit          = 1'b1;
            emit_status   = STAT_DUPLICATE;
          end else if (used >= CNT_W'(CELLS)) begin
            end_flag_next = (srch_pos >= used);
            emit          = 1'b1;
            emit_status   = STAT_FULL;
          end else begin
            idx_next  = used;
            ram_re    = 1'b1;
            ram_raddr = idx_dec_of(used);
          end
        end else begin
          ram_re = 1'b1;
        end
      end
      ST_COMPARE: begin
        srch_ctl.step = 1'b1;
      end
      ST_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = idx[IDX_W-1:0];
        ram_wdata = ram_rdata;
        idx_next  = idx_dec;
        if (idx_dec > cursor) begin
          ram_re    = 1'b1;
          ram_raddr = idx_dec_of(idx_dec);
        end
      end
      ST_WRITE: begin
        ram_we        = 1'b1;
        ram_waddr     = cursor[IDX_W-1:0];
        ram_wdata     = {key, val};
        used_next     = used + 1'b1;
        end_flag_next = 1'b0;
        emit          = 1'b1;
      end
      ST_READ: begin
        emit      = 1'b1;
        emit_data = 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase

    done_next               = emit;
    result_next.status      = emit_status;
    result_next.position    = INDEX_W'(cursor_next);
    result_next.found_key   = emit_data ? ram_rdata[VALUE_WIDTH +: KEY_W] : '0;
    result_next.found_value = emit_data ? VALUE_W'(ram_rdata[VALUE_WIDTH-1:0]) : '0;
    result_next.at_end      = end_flag_next;
    result_next.cell_count  = INDEX_W'(used_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      used     <= '0;
      cursor   <= '0;
      end_flag <= 1'b1;
      idx      <= '0;
      done     <= 1'b0;
    end else begin
      state    <= state_next;
      used     <= used_next;
      cursor   <= cursor_next;
      end_flag <= end_flag_next;
      idx      <= idx_next;
      done     <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act <= cmd.action;
      key <= cmd.search_key;
      val <= cmd.new_value[VALUE_WIDTH-1:0];
    end
    if (emit) begin
      result <= result_next;
    end
  end

endmodule

/* rtl/sltab_checker.sv */
// Port-level checks for the sorted leaf key table and the bind that attaches
// them to the top level. Depends on sltab_pkg and sorted_leaf_key_table.
module sltab_checker #(
  parameter int CELLS = sltab_pkg::DEF_CELLS
) (
  input logic                     clk,
  input logic                     rst,
  input logic                     start,
  input sltab_pkg::sltab_cmd_t    cmd,
  input logic                     busy,
  input logic                     done,
  input sltab_pkg::sltab_result_t result
);
  import sltab_pkg::*;

  localparam bit NARROW = (CELLS < 32);

  // Every accepted word either finishes at once or keeps the block busy.
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (done || busy))
    else $error("accepted word neither finished nor held busy");

  a_start_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && cmd.action == ACT_START) |=> (done && !busy))
    else $error("start scan did not finish in one cycle");

  a_cursor_in_range: assert property (@(posedge clk) disable iff (rst)
    (done && NARROW) |-> (result.position <= result.cell_count))
    else $error("cursor beyond the cell count");

  a_end_flag: assert property (@(posedge clk) disable iff (rst)
    (done && NARROW && !result.at_end) |-> (result.position < result.cell_count))
    else $error("end flag clear with cursor at the cell count");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == STAT_FULL) |-> (result.cell_count == INDEX_W'(CELLS)))
    else $error("full status with room left");

endmodule

bind sorted_leaf_key_table sltab_checker #(
  .CELLS(CELLS)
) u_sltab_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .cmd   (cmd),
  .busy  (busy),
  .done  (done),
  .result(result)
);
